// ===== sv/brq_pkg.sv =====
// Shared types, constants and codes for the byte ring queue.
package brq_pkg;

    // Queue geometry: a power of two from 2 to 256 slots.
    localparam int DEPTH  = 256;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed field widths of the request and result transactions.
    localparam int REQ_W  = 3;
    localparam int BYTE_W = 8;
    localparam int AMT_W  = 8;
    localparam int CNT_W  = 8;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUT       = 3'd0,
        REQ_GET       = 3'd1,
        REQ_PEEK      = 3'd2,
        REQ_FLUSH     = 3'd3,
        REQ_FLUSH_ALL = 3'd4
    } req_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    // Result of one request, apart from the byte read from the store.
    typedef struct packed {
        logic ok;
        logic use_mem;
        ptr_t free_cnt;
        ptr_t pend_cnt;
    } res_t;

    // Store write port.
    typedef struct packed {
        logic  we;
        ptr_t  addr;
        byte_t data;
    } mem_wr_t;

    // Store read port.
    typedef struct packed {
        logic re;
        ptr_t addr;
    } mem_rd_t;

endpackage

// ===== sv/brq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module brq_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(2**ADDR_W)-1:0];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/brq_ctrl.sv =====
// Queue controller: pointers, request decode, store clearing and result staging.
module brq_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [brq_pkg::REQ_W-1:0]   s_req_type,
    input  logic [brq_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic [brq_pkg::AMT_W-1:0]   s_amount,
    output logic                        res_valid,
    input  logic                        res_take,
    output brq_pkg::res_t               res,
    output brq_pkg::mem_wr_t            mem_wr,
    output brq_pkg::mem_rd_t            mem_rd
);

    brq_pkg::state_t state_reg, state_next;
    brq_pkg::ptr_t   wr_idx_reg, wr_idx_next;
    brq_pkg::ptr_t   rd_idx_reg, rd_idx_next;
    brq_pkg::ptr_t   clr_idx_reg, clr_idx_next;
    brq_pkg::res_t   res_reg, res_next;

    logic            in_fire;
    logic            clr_done;
    brq_pkg::ptr_t   pend_now;
    brq_pkg::ptr_t   free_now;
    brq_pkg::ptr_t   flush_amt;
    logic            req_ok;
    logic            req_use_mem;
    logic            put_we;
    logic            rd_re;
    brq_pkg::ptr_t   rd_addr;

    assign in_fire  = s_valid && s_ready;
    assign clr_done = (clr_idx_reg == brq_pkg::ptr_t'(brq_pkg::DEPTH - 1));

    // Occupancy before the request; one slot always stays empty.
    assign pend_now = brq_pkg::ptr_t'(wr_idx_reg - rd_idx_reg);
    assign free_now = brq_pkg::ptr_t'(rd_idx_reg - wr_idx_reg - brq_pkg::ptr_t'(1));

    // Flush count clamped to what is pending.
    always_comb begin
        if (s_amount > brq_pkg::AMT_W'(pend_now)) begin
            flush_amt = pend_now;
        end else begin
            flush_amt = s_amount[brq_pkg::PTR_W-1:0];
        end
    end

    // Request decode and pointer update.
    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        req_ok      = 1'b1;
        req_use_mem = 1'b0;
        put_we      = 1'b0;
        rd_re       = 1'b0;
        rd_addr     = rd_idx_reg;
        case (s_req_type)
            brq_pkg::REQ_PUT: begin
                if (free_now == '0) begin
                    req_ok = 1'b0;
                end else begin
                    put_we      = in_fire;
                    wr_idx_next = brq_pkg::ptr_t'(wr_idx_reg + brq_pkg::ptr_t'(1));
                end
            end
            brq_pkg::REQ_GET: begin
                if (pend_now == '0) begin
                    req_ok = 1'b0;
                end else begin
                    req_use_mem = 1'b1;
                    rd_re       = in_fire;
                    rd_idx_next = brq_pkg::ptr_t'(rd_idx_reg + brq_pkg::ptr_t'(1));
                end
            end
            brq_pkg::REQ_PEEK: begin
                req_use_mem = 1'b1;
                rd_re       = in_fire;
                rd_addr     = brq_pkg::ptr_t'(rd_idx_reg + s_amount[brq_pkg::PTR_W-1:0]);
            end
            brq_pkg::REQ_FLUSH: begin
                rd_idx_next = brq_pkg::ptr_t'(rd_idx_reg + flush_amt);
            end
            brq_pkg::REQ_FLUSH_ALL: begin
                rd_idx_next = wr_idx_reg;
            end
            default: begin
                req_ok = 1'b0;
            end
        endcase
    end

    // Result staging: counts after the request; clearing-pass index advance.
    always_comb begin
        res_next          = res_reg;
        clr_idx_next      = clr_idx_reg;
        if (in_fire) begin
            res_next.ok       = req_ok;
            res_next.use_mem  = req_use_mem;
            res_next.pend_cnt = brq_pkg::ptr_t'(wr_idx_next - rd_idx_next);
            res_next.free_cnt = brq_pkg::ptr_t'(rd_idx_next - wr_idx_next
                                                - brq_pkg::ptr_t'(1));
        end
        if (state_reg == brq_pkg::ST_CLEAR) begin
            clr_idx_next = brq_pkg::ptr_t'(clr_idx_reg + brq_pkg::ptr_t'(1));
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brq_pkg::ST_CLEAR: begin
                if (clr_done) begin
                    state_next = brq_pkg::ST_IDLE;
                end
            end
            brq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = brq_pkg::ST_BUSY;
                end
            end
            brq_pkg::ST_BUSY: begin
                if (res_take) begin
                    state_next = brq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brq_pkg::ST_CLEAR;
            end
        endcase
    end

    // State outputs and store ports.
    always_comb begin
        s_ready     = 1'b0;
        res_valid   = 1'b0;
        mem_wr.we   = put_we;
        mem_wr.addr = wr_idx_reg;
        mem_wr.data = s_data_byte;
        mem_rd.re   = rd_re;
        mem_rd.addr = rd_addr;
        case (state_reg)
            brq_pkg::ST_CLEAR: begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = clr_idx_reg;
                mem_wr.data = '0;
            end
            brq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            brq_pkg::ST_BUSY: begin
                res_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= brq_pkg::ST_CLEAR;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            clr_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (in_fire) begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // An accepted transaction is staged as a result in the next cycle.
    a_fire_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> res_valid)
        else $error("accepted transaction did not produce a staged result");

    // A successful put grows the pending count by one.
    a_put_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_req_type == brq_pkg::REQ_PUT && free_now != '0)
        |=> (pend_now == brq_pkg::ptr_t'($past(pend_now) + brq_pkg::ptr_t'(1))))
        else $error("put did not advance the write pointer");

    // Flush-all leaves the queue empty.
    a_flush_all_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_req_type == brq_pkg::REQ_FLUSH_ALL) |=> (pend_now == '0))
        else $error("flush-all left bytes pending");

    // A flush never drops more than was pending.
    a_flush_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_req_type == brq_pkg::REQ_FLUSH)
        |=> (pend_now <= $past(pend_now)))
        else $error("flush underflowed the queue");

    // The clearing pass sweeps one entry per cycle.
    a_clear_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == brq_pkg::ST_CLEAR && !clr_done)
        |=> (clr_idx_reg == brq_pkg::ptr_t'($past(clr_idx_reg) + brq_pkg::ptr_t'(1))))
        else $error("clearing pass skipped an entry");

endmodule

// ===== sv/byte_ring_queue_peek_flush.sv =====
// Top level of the byte ring queue with peek and flush.
//
// Requests arrive on the s_ channel (s_req_type, s_data_byte, s_amount) and
// each produces exactly one result on the m_ channel (m_ok, m_data_out,
// m_free_count, m_pending_count), in order. Both channels use valid/ready.
// Request codes: put, get, peek at an offset, flush a count, flush all.
// The queue holds at most DEPTH-1 bytes; every result carries the free and
// pending counts after its request.
// In the accept cycle pointers are updated and the store is written or read;
// the result is then staged in the controller and moves to the output register
// together with the registered read data of the store.
// A new request is accepted once the previous result has moved to the output
// register, also while that register still holds it waiting for m_ready.
// While the receiver stalls, at most one more result is staged inside the
// controller and s_ready stays low until it moves to the output register.
// After reset the store is cleared to zero, one entry per cycle, across all
// DEPTH (256) entries; s_ready stays low during that pass.
module byte_ring_queue_peek_flush (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [brq_pkg::REQ_W-1:0]   s_req_type,
    input  logic [brq_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic [brq_pkg::AMT_W-1:0]   s_amount,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [brq_pkg::BYTE_W-1:0]  m_data_out,
    output logic [brq_pkg::CNT_W-1:0]   m_free_count,
    output logic [brq_pkg::CNT_W-1:0]   m_pending_count
);

    logic                  res_valid;
    logic                  res_take;
    brq_pkg::res_t         res;
    brq_pkg::mem_wr_t      mem_wr;
    brq_pkg::mem_rd_t      mem_rd;
    brq_pkg::byte_t        mem_rdata;

    logic                  m_valid_reg, m_valid_next;
    logic                  ok_reg;
    brq_pkg::byte_t        data_reg;
    logic [brq_pkg::CNT_W-1:0] free_reg;
    logic [brq_pkg::CNT_W-1:0] pend_reg;

    brq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .s_amount    (s_amount),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_wr      (mem_wr),
        .mem_rd      (mem_rd)
    );

    brq_ram #(
        .ADDR_W (brq_pkg::PTR_W),
        .DATA_W (brq_pkg::BYTE_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_wr.we),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .re    (mem_rd.re),
        .raddr (mem_rd.addr),
        .rdata (mem_rdata)
    );

    // A staged result moves out when the output register is empty or drains.
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (res_take) begin
            ok_reg   <= res.ok;
            data_reg <= res.use_mem ? mem_rdata : '0;
            free_reg <= brq_pkg::CNT_W'(res.free_cnt);
            pend_reg <= brq_pkg::CNT_W'(res.pend_cnt);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = ok_reg;
    assign m_data_out      = data_reg;
    assign m_free_count    = free_reg;
    assign m_pending_count = pend_reg;

endmodule
